### hdl/tdtgs_pkg.sv
package tdtgs_pkg;

    localparam int WHEEL_BASE_MM_DEF = 145;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int MAX_STEPS         = 24;

    localparam logic signed [31:0] ANG_PI      = 32'sd52707179;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd26353589;

    localparam logic [6:0] SPEED_RESET = 7'd50;
    localparam logic [6:0] SPEED_MAX   = 7'd100;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_TURN   = 2'd1;
    localparam logic [1:0] PH_DRIVE  = 2'd2;
    localparam logic [1:0] PH_ORIENT = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'd13176795;
                5'd1:    r = 32'd7778716;
                5'd2:    r = 32'd4110060;
                5'd3:    r = 32'd2086331;
                5'd4:    r = 32'd1047214;
                5'd5:    r = 32'd524117;
                5'd6:    r = 32'd262123;
                5'd7:    r = 32'd131069;
                default: r = (i < 5'd24) ? (32'd65536 >> (i - 5'd8)) : 32'd0;
            endcase
            return r;
        end
    endfunction

    // Q30 gain of a rotate pass followed by a vector pass, truncated per step
    function automatic logic [63:0] cordic_gain(input int n);
        logic [63:0] g;
        begin
            g = 64'd1 << 30;
            for (int p = 0; p < 2; p++)
            begin
                for (int i = 0; i < n; i++)
                    g = g + (g >> (2 * i));
            end
            return g;
        end
    endfunction

endpackage

### hdl/tdtgs_if.sv
interface tdtgs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] goal_dx;
    logic [15:0] goal_dy;
    logic [14:0] start_heading;
    logic [14:0] final_heading;
    logic [31:0] left_count;
    modport source (output valid, cmd, goal_dx, goal_dy, start_heading, final_heading,
                    left_count, input ready);
    modport sink (input valid, cmd, goal_dx, goal_dy, start_heading, final_heading,
                  left_count, output ready);
endinterface

interface tdtgs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [1:0] phase;
    logic       done_res;
    modport source (output valid, left_drive, right_drive, phase, done_res, input ready);
    modport sink (input valid, left_drive, right_drive, phase, done_res, output ready);
endinterface

interface tdtgs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hdl/turn_drive_turn_goal_sequencer.sv
// channel | dir | payload
// in      | in  | cmd, goal_dx, goal_dy, start_heading, final_heading, left_count
// out     | out | left_drive, right_drive, phase, done_res
// cfg     | in  | data = cruise_speed
// After the input transfer a tick goes to S_RUN; a start first runs prerotate, rotate,
// vector, divide and arcs; a zero rotated offset skips vector and divide.
// One shared CORDIC add/shift unit runs rotate then vector; one multiplier does the
// reciprocal divide by the CORDIC gain and both arcs.
// Reset clears control and arc registers; cruise_speed resets to 50. No input taken
// while a result is held unaccepted; ready returns the cycle after the output transfer.
module turn_drive_turn_goal_sequencer
    import tdtgs_pkg::*;
#(
    parameter int WHEEL_BASE_MM = WHEEL_BASE_MM_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    tdtgs_in_if.sink    in_ch,
    tdtgs_out_if.source out_ch,
    tdtgs_cfg_if.sink   cfg
);

    localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic [32:0] ARC_K = 33'(2 * WHEEL_BASE_MM);
    localparam logic [63:0] GAIN_Q30 = cordic_gain(NSTEP);
    localparam logic [63:0] GAIN_RECIP = (64'd1 << 62) / GAIN_Q30;
    localparam logic [64:0] ARC_HALF = 65'd1 << 23;

    typedef enum logic [3:0] {
        S_IDLE, S_PREROT, S_ROT, S_VPRE, S_VEC, S_DIV, S_DIVC, S_A2, S_ARC1, S_ARC2,
        S_RUN, S_OUT
    } state_t;

    state_t state_reg;
    logic [6:0]  speed_reg;
    logic [1:0]  phase_reg;
    logic signed [31:0] seg_reg, left_reg;
    logic [31:0] turn_arc_reg, drive_reg, orient_arc_reg;
    logic [1:0]  turn_sign_reg, orient_sign_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]  step_reg;
    logic signed [31:0] a2_reg;
    logic signed [15:0] thd_reg;
    logic [31:0] mag_reg;
    logic [7:0]  ls_reg, rs_reg;
    logic [1:0]  oph_reg;
    logic        done_reg;

    logic signed [47:0] xs, ys;
    logic [31:0] atan_i;
    logic [6:0]  spd;
    logic signed [31:0] a_mag;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [64:0] prod;
    logic [63:0] rem_chk;
    logic signed [32:0] diff;
    logic [32:0] adiff;
    logic [31:0] target;
    logic [1:0]  sgn;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.left_drive  = ls_reg;
    assign out_ch.right_drive = rs_reg;
    assign out_ch.phase       = oph_reg;
    assign out_ch.done_res    = done_reg;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign atan_i = atan_lut(step_reg);
    assign spd = (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
    assign a_mag = (z_reg[31]) ? -z_reg[31:0] : z_reg[31:0];
    assign prod = mul_a * mul_b;
    assign rem_chk = {2'b00, x_reg[31:0], 30'd0} - prod[63:0];
    assign diff = 33'(left_reg) - 33'(seg_reg);
    assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb
    begin
        case (state_reg)
            S_DIV:   begin mul_a = x_reg[31:0]; mul_b = GAIN_RECIP[32:0]; end
            S_DIVC:  begin mul_a = mag_reg;     mul_b = GAIN_Q30[32:0];   end
            default: begin mul_a = a_mag;       mul_b = ARC_K;            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_TURN:  begin target = turn_arc_reg;   sgn = turn_sign_reg;   end
            PH_DRIVE: begin target = drive_reg;      sgn = 2'd1;            end
            default:  begin target = orient_arc_reg; sgn = orient_sign_reg; end
        endcase
    end

    function automatic logic [1:0] sign2(input logic signed [31:0] v);
        return v[31] ? 2'b11 : ((v != 0) ? 2'b01 : 2'b00);
    endfunction

    function automatic logic [7:0] mulsign(input logic [1:0] s, input logic [6:0] v);
        return (s == 2'b01) ? {1'b0, v} : ((s == 2'b11) ? -{1'b0, v} : 8'd0);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            speed_reg <= SPEED_RESET;
            phase_reg <= PH_IDLE;
            seg_reg <= '0;
            turn_arc_reg <= '0;
            drive_reg <= '0;
            orient_arc_reg <= '0;
            turn_sign_reg <= '0;
            orient_sign_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                speed_reg <= cfg.data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        left_reg <= in_ch.left_count;
                        if (in_ch.cmd == CMD_START)
                        begin
                            x_reg <= 48'($signed(in_ch.goal_dx)) <<< 12;
                            y_reg <= 48'($signed(in_ch.goal_dy)) <<< 12;
                            z_reg <= -(34'($signed(in_ch.start_heading)) <<< 12);
                            thd_reg <= 16'($signed(in_ch.final_heading))
                                       - 16'($signed(in_ch.start_heading));
                            step_reg <= '0;
                            state_reg <= S_PREROT;
                        end
                        else
                            state_reg <= S_RUN;
                    end
                end
                S_PREROT:
                begin
                    if (z_reg > 34'(ANG_HALF_PI))
                    begin
                        x_reg <= -x_reg; y_reg <= -y_reg; z_reg <= z_reg - 34'(ANG_PI);
                    end
                    else if (z_reg < -34'(ANG_HALF_PI))
                    begin
                        x_reg <= -x_reg; y_reg <= -y_reg; z_reg <= z_reg + 34'(ANG_PI);
                    end
                    state_reg <= (NSTEP == 0) ? S_VPRE : S_ROT;
                end
                S_ROT:
                begin
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs;
                        z_reg <= z_reg - 34'(atan_i);
                    end
                    else
                    begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs;
                        z_reg <= z_reg + 34'(atan_i);
                    end
                    if (step_reg == 5'(NSTEP - 1))
                    begin
                        step_reg <= '0;
                        state_reg <= S_VPRE;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_VPRE:
                begin
                    if (x_reg == 0 && y_reg == 0)
                    begin
                        z_reg <= '0;
                        mag_reg <= '0;
                        state_reg <= S_A2;
                    end
                    else if (x_reg < 0)
                    begin
                        z_reg <= (y_reg >= 0) ? 34'(ANG_PI) : -34'(ANG_PI);
                        x_reg <= -x_reg; y_reg <= -y_reg;
                        state_reg <= (NSTEP == 0) ? S_DIV : S_VEC;
                    end
                    else
                    begin
                        z_reg <= '0;
                        state_reg <= (NSTEP == 0) ? S_DIV : S_VEC;
                    end
                end
                S_VEC:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs;
                        z_reg <= z_reg + 34'(atan_i);
                    end
                    else
                    begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs;
                        z_reg <= z_reg - 34'(atan_i);
                    end
                    if (step_reg == 5'(NSTEP - 1))
                        state_reg <= S_DIV;
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_DIV:
                begin
                    // quotient estimate, at most one low
                    mag_reg <= (x_reg > 0) ? prod[63:32] : '0;
                    state_reg <= S_DIVC;
                end
                S_DIVC:
                begin
                    if (x_reg > 0 && rem_chk >= GAIN_Q30)
                        mag_reg <= mag_reg + 32'd1;
                    state_reg <= S_A2;
                end
                S_A2:
                begin
                    drive_reg <= 32'((33'(mag_reg) + 33'd512) >> 10);
                    turn_sign_reg <= sign2(z_reg[31:0]);
                    a2_reg <= (32'(thd_reg) <<< 12) - z_reg[31:0];
                    state_reg <= S_ARC1;
                end
                S_ARC1:
                begin
                    turn_arc_reg <= 32'((prod + ARC_HALF) >> 24);
                    z_reg <= 34'(a2_reg);
                    orient_sign_reg <= sign2(a2_reg);
                    state_reg <= S_ARC2;
                end
                S_ARC2:
                begin
                    orient_arc_reg <= 32'((prod + ARC_HALF) >> 24);
                    phase_reg <= PH_TURN;
                    seg_reg <= left_reg;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        ls_reg <= '0; rs_reg <= '0;
                        oph_reg <= PH_IDLE; done_reg <= 1'b0;
                    end
                    else if (adiff >= {1'b0, target} && phase_reg == PH_ORIENT)
                    begin
                        phase_reg <= PH_IDLE; oph_reg <= PH_IDLE;
                        ls_reg <= '0; rs_reg <= '0; done_reg <= 1'b1;
                    end
                    else
                    begin
                        ls_reg <= (phase_reg == PH_DRIVE) ? mulsign(sgn, spd)
                                                          : mulsign(-sgn, spd);
                        rs_reg <= mulsign(sgn, spd);
                        done_reg <= 1'b0;
                        if (adiff >= {1'b0, target})
                        begin
                            phase_reg <= phase_reg + 2'd1;
                            oph_reg <= phase_reg + 2'd1;
                            seg_reg <= left_reg;
                        end
                        else
                            oph_reg <= phase_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.left_drive))
        else $error("result dropped");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.done_res |-> out_ch.phase == PH_IDLE)
        else $error("done outside idle");

endmodule
